/* hw/rtl/gcd_pkg.sv */
`default_nettype none
package gcd_pkg;

	localparam int CORDIC_STAGES = 24;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	localparam logic signed [32:0] CORDIC_K     = 33'sd652032874;
	localparam logic [30:0]        DIV45_MUL    = 31'd1527099484;
	localparam logic [16:0]        DIV90_MUL    = 17'd93207;
	localparam logic [33:0]        PI_Q32       = 34'd13493037705;
	localparam logic [31:0]        QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
	localparam logic [25:0]        DIST_MAX     = 26'h3FF_FFFF;
	localparam logic [24:0]        BEAR_FULL    = 25'd23592960;

	localparam logic [27:0] REF_LAT_RST = 28'd44088090;
	localparam logic [28:0] REF_LON_RST = 29'd12895937;
	localparam logic [23:0] RADIUS_RST  = 24'd6371000;

	localparam int SQRT_STAGES = 31;
	localparam int FRONT_LAT   = 4;
	localparam int SC_LAT      = CORDIC_STAGES + 2;
	localparam int HAV_LAT     = 3;
	localparam int ISQRT_LAT   = SQRT_STAGES + 1;
	localparam int VEC_LAT     = CORDIC_STAGES + 2;
	localparam int DIST_LAT    = 3;
	localparam int TOTAL_LAT   = FRONT_LAT + SC_LAT + HAV_LAT + ISQRT_LAT + VEC_LAT + DIST_LAT;
	localparam int BEAR_DELAY  = SC_LAT + HAV_LAT + ISQRT_LAT + DIST_LAT;

	typedef enum logic [1:0] {
		REG_REF_LAT = 2'd0,
		REG_REF_LON = 2'd1,
		REG_RADIUS  = 2'd2
	} reg_addr_t;

	typedef struct packed {
		logic at_ref;
		logic lat_neg;
		logic lon_neg;
	} bear_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/gcd_front.sv */
`default_nettype none
module gcd_front (
	input  wire logic                clk,
	input  wire logic signed [27:0]  event_lat,
	input  wire logic signed [28:0]  event_lon,
	input  wire logic signed [27:0]  ref_lat,
	input  wire logic signed [28:0]  ref_lon,
	output logic [3:0][31:0]         turn,
	output logic [29:0]              mag_lat,
	output logic [29:0]              mag_lon,
	output gcd_pkg::bear_ctl_t       ctl
);
	import gcd_pkg::*;

	logic signed [28:0] dlat;
	logic signed [29:0] dlon;
	logic signed [29:0] op [4];
	logic [60:0] prod45 [4];
	logic [29:0] q45 [4];
	logic [15:0] num [4];
	logic [32:0] prod90 [4];
	logic [31:0] base [4];
	logic [31:0] mag32 [4];

	logic [29:0] mag_s1 [4];
	logic        neg_s1 [4];
	bear_ctl_t   ctl_s1;
	logic [29:0] mag_s2 [4];
	logic [23:0] quo_s2 [4];
	logic        neg_s2 [4];
	bear_ctl_t   ctl_s2;
	logic [5:0]  rem_s3 [4];
	logic [23:0] quo_s3 [4];
	logic        neg_s3 [4];
	logic [29:0] mlat_s3, mlon_s3;
	bear_ctl_t   ctl_s3;
	logic [31:0] turn_s4 [4];
	logic [29:0] mlat_s4, mlon_s4;
	bear_ctl_t   ctl_s4;

	always_comb begin
		dlat  = 29'(event_lat) - 29'(ref_lat);
		dlon  = 30'(event_lon) - 30'(ref_lon);
		op[0] = 30'(dlat);
		op[1] = dlon;
		op[2] = 30'(ref_lat);
		op[3] = 30'(event_lat);
		for (int k = 0; k < 4; k++) begin
			prod45[k] = 61'(mag_s1[k]) * 61'(DIV45_MUL);
			q45[k]    = {6'b0, quo_s2[k]} * 30'd45;
			if (k < 2) begin
				num[k]  = 16'({rem_s3[k], 9'b0}) + 16'd45;
				base[k] = {quo_s3[k], 8'b0};
			end else begin
				num[k]  = 16'({rem_s3[k], 10'b0}) + 16'd45;
				base[k] = 32'({quo_s3[k], 9'b0});
			end
			prod90[k] = 33'(num[k]) * 33'(DIV90_MUL);
			mag32[k]  = base[k] + 32'(prod90[k][32:23]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			neg_s1[k] <= op[k][29];
			mag_s1[k] <= op[k][29] ? 30'(-op[k]) : 30'(op[k]);
			mag_s2[k] <= mag_s1[k];
			quo_s2[k] <= prod45[k][59:36];
			neg_s2[k] <= neg_s1[k];
			rem_s3[k] <= 6'(mag_s2[k] - q45[k]);
			quo_s3[k] <= quo_s2[k];
			neg_s3[k] <= neg_s2[k];
			turn_s4[k] <= neg_s3[k] ? (32'd0 - mag32[k]) : mag32[k];
		end
		ctl_s1.at_ref  <= (dlat == 29'sd0) && (dlon == 30'sd0);
		ctl_s1.lat_neg <= dlat[28];
		ctl_s1.lon_neg <= dlon[29];
		ctl_s2  <= ctl_s1;
		ctl_s3  <= ctl_s2;
		ctl_s4  <= ctl_s3;
		mlat_s3 <= mag_s2[0];
		mlon_s3 <= mag_s2[1];
		mlat_s4 <= mlat_s3;
		mlon_s4 <= mlon_s3;
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			turn[k] = turn_s4[k];
		end
	end

	assign mag_lat = mlat_s4;
	assign mag_lon = mlon_s4;
	assign ctl     = ctl_s4;

endmodule
`default_nettype wire

/* hw/rtl/gcd_sincos.sv */
`default_nettype none
module gcd_sincos (
	input  wire logic               clk,
	input  wire logic [31:0]        ang,
	output logic signed [31:0]      cosv,
	output logic signed [31:0]      sinv
);
	import gcd_pkg::*;

	logic [31:0] ang_off;
	logic [1:0]  quad;
	logic [31:0] zr;

	logic signed [32:0] x_s [CORDIC_STAGES+1];
	logic signed [32:0] y_s [CORDIC_STAGES+1];
	logic signed [32:0] z_s [CORDIC_STAGES+1];
	logic [1:0]         quad_s [CORDIC_STAGES+1];
	logic signed [31:0] cos_s, sin_s;

	always_comb begin
		ang_off = ang + 32'h2000_0000;
		quad    = ang_off[31:30];
		zr      = ang - {quad, 30'b0};
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_K;
		y_s[0]    <= 33'sd0;
		z_s[0]    <= 33'(signed'(zr));
		quad_s[0] <= quad;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - 33'(ATAN_TAB[i]);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + 33'(ATAN_TAB[i]);
			end
			quad_s[i+1] <= quad_s[i];
		end
		case (quad_s[CORDIC_STAGES])
			2'd0: begin
				cos_s <= 32'(x_s[CORDIC_STAGES]);
				sin_s <= 32'(y_s[CORDIC_STAGES]);
			end
			2'd1: begin
				cos_s <= 32'(-y_s[CORDIC_STAGES]);
				sin_s <= 32'(x_s[CORDIC_STAGES]);
			end
			2'd2: begin
				cos_s <= 32'(-x_s[CORDIC_STAGES]);
				sin_s <= 32'(-y_s[CORDIC_STAGES]);
			end
			default: begin
				cos_s <= 32'(y_s[CORDIC_STAGES]);
				sin_s <= 32'(-x_s[CORDIC_STAGES]);
			end
		endcase
	end

	assign cosv = cos_s;
	assign sinv = sin_s;

endmodule
`default_nettype wire

/* hw/rtl/gcd_hav.sv */
`default_nettype none
module gcd_hav (
	input  wire logic               clk,
	input  wire logic signed [31:0] s1,
	input  wire logic signed [31:0] s2,
	input  wire logic signed [31:0] cr,
	input  wire logic signed [31:0] ce,
	output logic [60:0]             hav,
	output logic [60:0]             hav_c
);
	import gcd_pkg::*;

	localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

	logic signed [63:0] pu, pv;
	logic signed [64:0] sum;
	logic [60:0]        clamped;

	logic signed [31:0] u_s1, v_s1, s1_s1;
	logic signed [63:0] p1_s2, p2_s2;
	logic [60:0]        hav_s3, havc_s3;

	always_comb begin
		pu  = 64'(s2) * 64'(cr);
		pv  = 64'(s2) * 64'(ce);
		sum = 65'(p1_s2) + 65'(p2_s2);
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > signed'(65'(ONE_Q60))) begin
			clamped = ONE_Q60;
		end else begin
			clamped = 61'(sum);
		end
	end

	always_ff @(posedge clk) begin
		u_s1    <= 32'((pu + 64'sd536870912) >>> 30);
		v_s1    <= 32'((pv + 64'sd536870912) >>> 30);
		s1_s1   <= s1;
		p1_s2   <= 64'(s1_s1) * 64'(s1_s1);
		p2_s2   <= 64'(u_s1) * 64'(v_s1);
		hav_s3  <= clamped;
		havc_s3 <= ONE_Q60 - clamped;
	end

	assign hav   = hav_s3;
	assign hav_c = havc_s3;

endmodule
`default_nettype wire

/* hw/rtl/gcd_isqrt.sv */
`default_nettype none
module gcd_isqrt (
	input  wire logic        clk,
	input  wire logic [60:0] val,
	output logic [30:0]      root
);
	import gcd_pkg::*;

	logic [60:0] rem_s [SQRT_STAGES+1];
	logic [60:0] r_s [SQRT_STAGES+1];
	logic [61:0] trial [SQRT_STAGES];

	always_comb begin
		for (int k = 0; k < SQRT_STAGES; k++) begin
			trial[k] = {1'b0, r_s[k]} + (62'd1 << (60 - 2 * k));
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= val;
		r_s[0]   <= '0;
		for (int k = 0; k < SQRT_STAGES; k++) begin
			if ({1'b0, rem_s[k]} >= trial[k]) begin
				rem_s[k+1] <= 61'({1'b0, rem_s[k]} - trial[k]);
				r_s[k+1]   <= (r_s[k] >> 1) + (61'd1 << (60 - 2 * k));
			end else begin
				rem_s[k+1] <= rem_s[k];
				r_s[k+1]   <= r_s[k] >> 1;
			end
		end
	end

	assign root = r_s[SQRT_STAGES][30:0];

endmodule
`default_nettype wire

/* hw/rtl/gcd_vec.sv */
`default_nettype none
module gcd_vec (
	input  wire logic        clk,
	input  wire logic [30:0] xin,
	input  wire logic [30:0] yin,
	output logic [30:0]      angle
);
	import gcd_pkg::*;

	logic signed [57:0] x_s [CORDIC_STAGES+1];
	logic signed [57:0] y_s [CORDIC_STAGES+1];
	logic signed [33:0] z_s [CORDIC_STAGES+1];
	logic               xz_s [CORDIC_STAGES+1];
	logic               yz_s [CORDIC_STAGES+1];
	logic [30:0]        ang_s;

	always_ff @(posedge clk) begin
		x_s[0]  <= 58'({xin, 24'b0});
		y_s[0]  <= 58'({yin, 24'b0});
		z_s[0]  <= 34'sd0;
		xz_s[0] <= (xin == 31'd0);
		yz_s[0] <= (yin == 31'd0);
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + 34'(ATAN_TAB[i]);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - 34'(ATAN_TAB[i]);
			end
			xz_s[i+1] <= xz_s[i];
			yz_s[i+1] <= yz_s[i];
		end
		if (yz_s[CORDIC_STAGES]) begin
			ang_s <= '0;
		end else if (xz_s[CORDIC_STAGES]) begin
			ang_s <= 31'(QUARTER_TURN);
		end else if (z_s[CORDIC_STAGES] < 0) begin
			ang_s <= '0;
		end else if (z_s[CORDIC_STAGES] > signed'(34'(QUARTER_TURN))) begin
			ang_s <= 31'(QUARTER_TURN);
		end else begin
			ang_s <= 31'(z_s[CORDIC_STAGES]);
		end
	end

	assign angle = ang_s;

endmodule
`default_nettype wire

/* hw/rtl/gcd_dist.sv */
`default_nettype none
module gcd_dist (
	input  wire logic        clk,
	input  wire logic [23:0] radius,
	input  wire logic [30:0] z,
	output logic [25:0]      dist_m
);
	import gcd_pkg::*;

	logic [63:0] lo_sum;
	logic [27:0] total;

	logic [54:0] m_s1;
	logic [61:0] ah_s2;
	logic [60:0] bb_s2;
	logic [25:0] dist_s3;

	always_comb begin
		lo_sum = 64'({ah_s2[34:0], 27'b0}) + 64'(bb_s2) + 64'h2000_0000_0000_0000;
		total  = 28'(ah_s2[61:35]) + 28'(lo_sum[63:62]);
	end

	always_ff @(posedge clk) begin
		m_s1    <= 55'(radius) * 55'(z);
		ah_s2   <= 62'(m_s1[54:27]) * 62'(PI_Q32);
		bb_s2   <= 61'(m_s1[26:0]) * 61'(PI_Q32);
		dist_s3 <= (total > 28'(DIST_MAX)) ? DIST_MAX : total[25:0];
	end

	assign dist_m = dist_s3;

endmodule
`default_nettype wire

/* hw/rtl/great_circle_distance_and_bearing_unit.sv */
// Channel   Ports                                        Transaction
// command   start, busy, event_lat, event_lon            start high, busy low at clk edge
// result    done, distance_m, bearing, at_reference      done high for one cycle
// config    psel, penable, pwrite, paddr, pwdata,        write at access cycle, pready high
//           prdata, pready
// One position enters every cycle; busy is always low.
// The two CORDIC chains and the square root pipeline lie in series on the distance path.
// Reset clears the valid pipeline and loads the reference point and radius defaults.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none
module great_circle_distance_and_bearing_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [27:0] event_lat,
	input  wire logic signed [28:0] event_lon,
	output logic                    done,
	output logic [25:0]             distance_m,
	output logic [24:0]             bearing,
	output logic                    at_reference,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import gcd_pkg::*;

	logic signed [27:0] ref_lat_q;
	logic signed [28:0] ref_lon_q;
	logic [23:0]        radius_q;

	logic               accept;
	logic [3:0][31:0]   turn;
	logic [29:0]        mag_lat, mag_lon;
	bear_ctl_t          ctl;
	logic signed [31:0] sin_dlat, sin_dlon, cos_rlat, cos_elat;
	logic [60:0]        hav_a, hav_c;
	logic [30:0]        root_a, root_b;
	logic [30:0]        zdist, qbear;
	logic [31:0]        bang;
	logic [40:0]        bprod;
	logic [24:0]        bval;
	bear_ctl_t          bc;

	logic      vld_s [TOTAL_LAT];
	bear_ctl_t bctl_s [VEC_LAT];
	logic [25:0] bdly_s [BEAR_DELAY];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= REF_LAT_RST;
			ref_lon_q <= REF_LON_RST;
			radius_q  <= RADIUS_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_addr_t'(paddr[3:2]))
				REG_REF_LAT: ref_lat_q <= pwdata[27:0];
				REG_REF_LON: ref_lon_q <= pwdata[28:0];
				REG_RADIUS:  radius_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_addr_t'(paddr[3:2]))
			REG_REF_LAT: prdata = 32'({ref_lat_q});
			REG_REF_LON: prdata = 32'({ref_lon_q});
			REG_RADIUS:  prdata = 32'(radius_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= accept;
			for (int i = 1; i < TOTAL_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	gcd_front u_front (
		.clk       (clk),
		.event_lat (event_lat),
		.event_lon (event_lon),
		.ref_lat   (ref_lat_q),
		.ref_lon   (ref_lon_q),
		.turn      (turn),
		.mag_lat   (mag_lat),
		.mag_lon   (mag_lon),
		.ctl       (ctl)
	);

	gcd_sincos u_sc_dlat (.clk(clk), .ang(turn[0]), .cosv(), .sinv(sin_dlat));
	gcd_sincos u_sc_dlon (.clk(clk), .ang(turn[1]), .cosv(), .sinv(sin_dlon));
	gcd_sincos u_sc_rlat (.clk(clk), .ang(turn[2]), .cosv(cos_rlat), .sinv());
	gcd_sincos u_sc_elat (.clk(clk), .ang(turn[3]), .cosv(cos_elat), .sinv());

	gcd_hav u_hav (
		.clk   (clk),
		.s1    (sin_dlat),
		.s2    (sin_dlon),
		.cr    (cos_rlat),
		.ce    (cos_elat),
		.hav   (hav_a),
		.hav_c (hav_c)
	);

	gcd_isqrt u_sqrt_a (.clk(clk), .val(hav_a), .root(root_a));
	gcd_isqrt u_sqrt_b (.clk(clk), .val(hav_c), .root(root_b));

	gcd_vec u_vec_dist (.clk(clk), .xin(root_b), .yin(root_a), .angle(zdist));

	gcd_dist u_dist (.clk(clk), .radius(radius_q), .z(zdist), .dist_m(distance_m));

	gcd_vec u_vec_bear (
		.clk   (clk),
		.xin   (31'(mag_lat)),
		.yin   (31'(mag_lon)),
		.angle (qbear)
	);

	always_comb begin
		bc = bctl_s[VEC_LAT-1];
		if (!bc.lat_neg && !bc.lon_neg) begin
			bang = 32'(qbear);
		end else if (bc.lat_neg && !bc.lon_neg) begin
			bang = HALF_TURN - 32'(qbear);
		end else if (bc.lat_neg) begin
			bang = HALF_TURN + 32'(qbear);
		end else begin
			bang = 32'd0 - 32'(qbear);
		end
		bprod = 41'(bang) * 41'd360 + 41'd32768;
		if (bc.at_ref || (bprod[40:16] >= BEAR_FULL)) begin
			bval = '0;
		end else begin
			bval = bprod[40:16];
		end
	end

	always_ff @(posedge clk) begin
		bctl_s[0] <= ctl;
		for (int i = 1; i < VEC_LAT; i++) begin
			bctl_s[i] <= bctl_s[i-1];
		end
		bdly_s[0] <= {bc.at_ref, bval};
		for (int i = 1; i < BEAR_DELAY; i++) begin
			bdly_s[i] <= bdly_s[i-1];
		end
	end

	assign done         = vld_s[TOTAL_LAT-1];
	assign bearing      = bdly_s[BEAR_DELAY-1][24:0];
	assign at_reference = bdly_s[BEAR_DELAY-1][25];

	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, TOTAL_LAT))
		else $error("result strobe without a matching command");

	a_ref_zero_bearing: assert property (@(posedge clk) disable iff (!arst_n)
		(done && at_reference) |-> (bearing == 25'd0))
		else $error("bearing not zero at reference point");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bearing < BEAR_FULL))
		else $error("bearing out of range");

endmodule
`default_nettype wire

/* tb/sv/great_circle_distance_and_bearing_unit_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_and_bearing_unit_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [27:0] event_lat,
	input  wire logic signed [28:0] event_lon,
	input  wire logic               done,
	input  wire logic [25:0]        distance_m,
	input  wire logic [24:0]        bearing,
	input  wire logic               at_reference,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	output int                      fail_count,
	output int                      pending
);
	import gcd_pkg::*;

	typedef struct packed {
		logic [25:0] meters;
		logic [24:0] bear;
		logic        atref;
	} fix_t;

	fix_t fix_queue[$];
	logic [27:0] cur_lat;
	logic [28:0] cur_lon;
	logic [23:0] cur_radius;

	function automatic longint asr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -64'sd1 - ((-64'sd1 - v) >>> s);
	endfunction

	function automatic logic [31:0] deg_to_turn(longint v, longint scale);
		longint n;
		longint q;
		n = v * scale;
		if (n >= 0)
			q = (n + 180) / 360;
		else
			q = -((-n + 180) / 360);
		return q[31:0];
	endfunction

	function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
		logic [31:0] quad;
		longint z;
		longint x;
		longint y;
		longint t;
		quad = (ang + 32'h2000_0000) >> 30;
		z = longint'({32'd0, ang - (quad << 30)});
		x = CORDIC_K;
		y = 0;
		if (z >= longint'({32'd0, HALF_TURN}))
			z -= 64'sd1 << 32;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				t = x - asr(y, i); y = y + asr(x, i); x = t;
				z -= longint'({32'd0, ATAN_TAB[i]});
			end else begin
				t = x + asr(y, i); y = y - asr(x, i); x = t;
				z += longint'({32'd0, ATAN_TAB[i]});
			end
		end
		case (quad[1:0])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic [31:0] arctan(longint x, longint y);
		longint z;
		longint t;
		z = 0;
		if (y == 0)
			return 32'd0;
		if (x == 0)
			return QUARTER_TURN;
		x *= 16777216;
		y *= 16777216;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (y >= 0) begin
				t = x + asr(y, i); y = y - asr(x, i); x = t;
				z += longint'({32'd0, ATAN_TAB[i]});
			end else begin
				t = x - asr(y, i); y = y + asr(x, i); x = t;
				z -= longint'({32'd0, ATAN_TAB[i]});
			end
		end
		if (z < 0)
			z = 0;
		if (z > longint'({32'd0, QUARTER_TURN}))
			z = longint'({32'd0, QUARTER_TURN});
		return z[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic fix_t locate(logic signed [27:0] lat_in, logic signed [28:0] lon_in);
		longint lat, lon, la0, lo0, dlat, dlon;
		longint c1, s1, c2, s2, cr, ce, u, v, a;
		logic [63:0] sa, sb, m, mh, ml, ah, alo, bb, dval, bear;
		logic [31:0] z, q, ang;
		fix_t f;
		lat = lat_in;
		lon = lon_in;
		la0 = longint'($signed(cur_lat));
		lo0 = longint'($signed(cur_lon));
		dlat = lat - la0;
		dlon = lon - lo0;
		rotate(deg_to_turn(dlat, 2048), c1, s1);
		rotate(deg_to_turn(dlon, 2048), c2, s2);
		rotate(deg_to_turn(la0, 4096), cr, u);
		rotate(deg_to_turn(lat, 4096), ce, v);
		u = asr(s2 * cr + (64'sd1 << 29), 30);
		v = asr(s2 * ce + (64'sd1 << 29), 30);
		a = s1 * s1 + u * v;
		if (a < 0)
			a = 0;
		if (a > (64'sd1 << 60))
			a = 64'sd1 << 60;
		sa = int_sqrt(a);
		sb = int_sqrt((64'd1 << 60) - a);
		z = arctan(sb, sa);
		m = {40'd0, cur_radius} * {32'd0, z};
		mh = m >> 27;
		ml = m & ((64'd1 << 27) - 1);
		ah = mh * {30'd0, PI_Q32};
		bb = ml * {30'd0, PI_Q32};
		alo = ah & ((64'd1 << 35) - 1);
		dval = (ah >> 35) + (((alo << 27) + bb + (64'd1 << 61)) >> 62);
		if (dval > {38'd0, DIST_MAX})
			dval = {38'd0, DIST_MAX};
		f.atref = (dlat == 0 && dlon == 0);
		if (f.atref) begin
			bear = 0;
		end else begin
			q = arctan(dlat < 0 ? -dlat : dlat, dlon < 0 ? -dlon : dlon);
			if (dlat >= 0 && dlon >= 0)
				ang = q;
			else if (dlat < 0 && dlon >= 0)
				ang = HALF_TURN - q;
			else if (dlat < 0)
				ang = HALF_TURN + q;
			else
				ang = 32'd0 - q;
			bear = ({32'd0, ang} * 360 + 32768) >> 16;
			if (bear >= {39'd0, BEAR_FULL})
				bear = 0;
		end
		f.meters = dval[25:0];
		f.bear = bear[24:0];
		return f;
	endfunction

	assign pending = fix_queue.size();

	always @(posedge clk or negedge arst_n) begin
		fix_t e;
		int errs;
		if (!arst_n) begin
			cur_lat <= REF_LAT_RST;
			cur_lon <= REF_LON_RST;
			cur_radius <= RADIUS_RST;
			fail_count <= 0;
			fix_queue.delete();
		end else begin
			errs = 0;
			if (done) begin
				if (fix_queue.size() == 0) begin
					$error("unexpected result transaction");
					errs = errs + 1;
				end else begin
					e = fix_queue.pop_front();
					if (distance_m !== e.meters) begin
						$error("distance_m expected %0d actual %0d", e.meters, distance_m);
						errs = errs + 1;
					end
					if (bearing !== e.bear) begin
						$error("bearing expected %0d actual %0d", e.bear, bearing);
						errs = errs + 1;
					end
					if (at_reference !== e.atref) begin
						$error("at_reference expected %0d actual %0d", e.atref, at_reference);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (start && !busy)
				fix_queue.push_back(locate(event_lat, event_lon));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_REF_LAT: cur_lat <= pwdata[27:0];
					REG_REF_LON: cur_lon <= pwdata[28:0];
					REG_RADIUS: cur_radius <= pwdata[23:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* tb/sv/great_circle_distance_and_bearing_unit_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_and_bearing_unit_test;
	import gcd_pkg::*;

	localparam int LAT_MAX = 94371840;
	localparam int LON_MAX = 188743680;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [27:0] event_lat = '0;
	logic signed [28:0] event_lon = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, at_reference, pready;
	logic [25:0] distance_m;
	logic [24:0] bearing;
	logic [31:0] prdata;
	int fail_count, pending;
	int gap_pct;
	int idle_cycles = 0;
	logic [27:0] lat0;
	logic [28:0] lon0;

	always #5 clk = ~clk;

	great_circle_distance_and_bearing_unit dut (.*);

	great_circle_distance_and_bearing_unit_checker checker_i (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("great_circle_distance_and_bearing_unit: mismatch");
			$finish;
		end
	end

	task automatic write_reg(reg_addr_t idx, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send(int lat, int lon);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		event_lat <= 28'(lat);
		event_lon <= 29'(lon);
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 10) @(posedge clk);
	endtask

	task automatic set_ref(int lat, int lon, int radius);
		write_reg(REG_REF_LAT, lat);
		write_reg(REG_REF_LON, lon);
		write_reg(REG_RADIUS, radius);
		lat0 = 28'(lat);
		lon0 = 29'(lon);
	endtask

	function automatic int rnd_range(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	task automatic random_items(int count);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(9);
			case (kind)
				0: send($urandom, $urandom);
				1: send(lat0, lon0);
				2: send(lat0, $signed(lon0) + rnd_range(1000));
				3: send($signed(lat0) + rnd_range(1000), lon0);
				4: send($signed(lat0) + rnd_range(50), $signed(lon0) + rnd_range(50));
				default: send(rnd_range(LAT_MAX), rnd_range(LON_MAX));
			endcase
		end
	endtask

	initial begin
		gap_pct = 15;
		lat0 = REF_LAT_RST;
		lon0 = REF_LON_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(lat0, lon0);
		send($signed(lat0) + 100, lon0);
		send($signed(lat0) - 100, lon0);
		send(lat0, $signed(lon0) + 100);
		send(lat0, $signed(lon0) - 100);
		send(LAT_MAX, LON_MAX);
		send(-LAT_MAX, -LON_MAX);
		send(LAT_MAX, -LON_MAX);
		send(-LAT_MAX, LON_MAX);
		send(28'sh7FFFFFF, 29'sh0FFFFFFF);
		send(28'sh8000000, 29'sh10000000);
		send(28'hFFFFFFF, 29'h1FFFFFFF);
		send(0, 0);
		send(-$signed(lat0), $signed(lon0) + 188743680);
		drain();
		set_ref(0, 0, 24'hFFFFFF);
		send(0, 0);
		send(0, LON_MAX);
		send(LAT_MAX, 0);
		send(-LAT_MAX, LON_MAX);
		send(1, 1);
		drain();
		set_ref(-LAT_MAX, LON_MAX, 1);
		send(LAT_MAX, -LON_MAX);
		send(-LAT_MAX, LON_MAX);
		send(0, 0);
		drain();
		set_ref(LAT_MAX, -LON_MAX, 0);
		send(-LAT_MAX, LON_MAX);
		send(0, 0);
		drain();
		write_reg(REG_REF_LAT, 32'h0FFF_FFFF);
		write_reg(REG_REF_LON, 32'h1FFF_FFFF);
		write_reg(REG_RADIUS, 32'h00FF_FFFF);
		lat0 = 28'hFFFFFFF;
		lon0 = 29'h1FFFFFFF;
		random_items(150);
		drain();
		set_ref(REF_LAT_RST, REF_LON_RST, RADIUS_RST);
		random_items(500);
		drain();
		gap_pct = 83;
		set_ref(rnd_range(LAT_MAX), rnd_range(LON_MAX), $urandom_range(1, 24'hFFFFFF));
		random_items(450);
		drain();
		gap_pct = 0;
		set_ref(rnd_range(LAT_MAX), rnd_range(LON_MAX), $urandom_range(1, 24'hFFFFFF));
		random_items(520);
		drain();
		if (fail_count == 0)
			$display("great_circle_distance_and_bearing_unit: match");
		else
			$display("great_circle_distance_and_bearing_unit: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
